// ===== rtl/crc16fr_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the frame receiver.
`timescale 1ns / 1ps

package crc16fr_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'h55;
    localparam logic [7:0]  SYNC_SECOND = 8'hAA;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    // Configuration register defaults and port geometry
    localparam logic [7:0] LOCAL_ADDR_RESET = 8'd1;
    localparam logic [7:0] BCAST_ADDR_RESET = 8'd0;
    localparam int         APB_ADDR_W       = 3;
    localparam int         APB_DATA_W       = 32;

    typedef enum logic [0:0] {
        REG_LOCAL_ADDR = 1'b0,
        REG_BCAST_ADDR = 1'b1
    } t_reg_index;

    typedef enum logic [2:0] {
        PH_SYNC1  = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_ADDR   = 3'd2,
        PH_FUNC   = 3'd3,
        PH_LEN    = 3'd4,
        PH_DATA   = 3'd5,
        PH_CRC_LO = 3'd6,
        PH_CRC_HI = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SYNC1 = 3'd1,
        ST_BAD_SYNC2 = 3'd2,
        ST_BAD_ADDR  = 3'd3,
        ST_BAD_CRC   = 3'd4
    } t_status;

    typedef struct packed {
        t_status    status;
        logic       was_broadcast;
        logic [7:0] function_code;
        logic [7:0] payload_length;
        logic [7:0] data_first;
        logic [7:0] data_second;
    } t_result;

    // Reflected CRC-16, one byte unrolled over eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc16fr_parser.sv =====
// Frame parser: phase machine, running CRC and held frame fields.
`timescale 1ns / 1ps

module crc16fr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_local_addr,
    input  logic [7:0]           i_bcast_addr,
    output logic                 o_res_valid,
    output crc16fr_pkg::t_result o_res
);

    crc16fr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic        r_bflag, n_bflag;
    logic [7:0]  r_func, n_func;
    logic [7:0]  r_length, n_length;
    logic [7:0]  r_data0, n_data0;
    logic [7:0]  r_data1, n_data1;
    logic [7:0]  r_crc_low, n_crc_low;

    logic        sync1_ok, sync2_ok, addr_local, addr_bcast, crc_ok, hunt;
    logic [15:0] crc_upd;
    logic [7:0]  data_idx;

    assign sync1_ok   = (i_byte == crc16fr_pkg::SYNC_FIRST);
    assign sync2_ok   = (i_byte == crc16fr_pkg::SYNC_SECOND);
    assign addr_local = (i_byte == i_local_addr);
    assign addr_bcast = (i_byte == i_bcast_addr);
    assign crc_ok     = (r_crc_low == r_crc[7:0]) && (i_byte == r_crc[15:8]);
    assign crc_upd    = crc16fr_pkg::crc_byte(r_crc, i_byte);
    assign data_idx   = r_length - r_bytes_left;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                crc16fr_pkg::PH_SYNC1:
                    n_phase = sync1_ok ? crc16fr_pkg::PH_SYNC2 : crc16fr_pkg::PH_SYNC1;
                crc16fr_pkg::PH_SYNC2:
                    n_phase = sync2_ok ? crc16fr_pkg::PH_ADDR : crc16fr_pkg::PH_SYNC1;
                crc16fr_pkg::PH_ADDR:
                    n_phase = (addr_local || addr_bcast) ? crc16fr_pkg::PH_FUNC
                                                         : crc16fr_pkg::PH_SYNC1;
                crc16fr_pkg::PH_FUNC:
                    n_phase = crc16fr_pkg::PH_LEN;
                crc16fr_pkg::PH_LEN:
                    n_phase = (i_byte == 8'd0) ? crc16fr_pkg::PH_CRC_LO : crc16fr_pkg::PH_DATA;
                crc16fr_pkg::PH_DATA:
                    n_phase = (r_bytes_left == 8'd1) ? crc16fr_pkg::PH_CRC_LO
                                                     : crc16fr_pkg::PH_DATA;
                crc16fr_pkg::PH_CRC_LO:
                    n_phase = crc16fr_pkg::PH_CRC_HI;
                crc16fr_pkg::PH_CRC_HI:
                    n_phase = crc16fr_pkg::PH_SYNC1;
                default:
                    n_phase = crc16fr_pkg::PH_SYNC1;
            endcase
        end
    end

    // Datapath updates and result
    always_comb begin
        n_crc        = r_crc;
        n_bytes_left = r_bytes_left;
        n_bflag      = r_bflag;
        n_func       = r_func;
        n_length     = r_length;
        n_data0      = r_data0;
        n_data1      = r_data1;
        n_crc_low    = r_crc_low;
        hunt         = 1'b0;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.status = crc16fr_pkg::ST_OK;
        if (i_accept) begin
            case (r_phase)
                crc16fr_pkg::PH_SYNC1: begin
                    if (!sync1_ok) begin
                        hunt         = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.status = crc16fr_pkg::ST_BAD_SYNC1;
                    end
                end
                crc16fr_pkg::PH_SYNC2: begin
                    if (!sync2_ok) begin
                        hunt         = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.status = crc16fr_pkg::ST_BAD_SYNC2;
                    end else begin
                        n_crc = crc16fr_pkg::CRC_INIT;
                    end
                end
                crc16fr_pkg::PH_ADDR: begin
                    if (addr_local || addr_bcast) begin
                        // local match wins when both registers hold the same value
                        n_bflag = !addr_local;
                        n_data0 = 8'd0;
                        n_data1 = 8'd0;
                        n_crc   = crc_upd;
                    end else begin
                        hunt         = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.status = crc16fr_pkg::ST_BAD_ADDR;
                    end
                end
                crc16fr_pkg::PH_FUNC: begin
                    n_func = i_byte;
                    n_crc  = crc_upd;
                end
                crc16fr_pkg::PH_LEN: begin
                    n_length     = i_byte;
                    n_bytes_left = i_byte;
                    n_crc        = crc_upd;
                end
                crc16fr_pkg::PH_DATA: begin
                    if (data_idx == 8'd0) begin
                        n_data0 = i_byte;
                    end else if (data_idx == 8'd1) begin
                        n_data1 = i_byte;
                    end
                    n_crc        = crc_upd;
                    n_bytes_left = r_bytes_left - 8'd1;
                end
                crc16fr_pkg::PH_CRC_LO: begin
                    n_crc_low = i_byte;
                end
                crc16fr_pkg::PH_CRC_HI: begin
                    hunt        = 1'b1;
                    o_res_valid = 1'b1;
                    if (crc_ok) begin
                        o_res.status         = crc16fr_pkg::ST_OK;
                        o_res.was_broadcast  = r_bflag;
                        o_res.function_code  = r_func;
                        o_res.payload_length = r_length;
                        o_res.data_first     = r_data0;
                        o_res.data_second    = r_data1;
                    end else begin
                        o_res.status = crc16fr_pkg::ST_BAD_CRC;
                    end
                end
                default: begin
                    hunt = 1'b1;
                end
            endcase
        end
        // Drop back to sync hunting with cleared frame state
        if (hunt) begin
            n_crc        = crc16fr_pkg::CRC_INIT;
            n_bytes_left = 8'd0;
            n_bflag      = 1'b0;
            n_func       = 8'd0;
            n_length     = 8'd0;
            n_data0      = 8'd0;
            n_data1      = 8'd0;
            n_crc_low    = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= crc16fr_pkg::PH_SYNC1;
            r_crc        <= crc16fr_pkg::CRC_INIT;
            r_bytes_left <= 8'd0;
            r_bflag      <= 1'b0;
            r_func       <= 8'd0;
            r_length     <= 8'd0;
            r_data0      <= 8'd0;
            r_data1      <= 8'd0;
            r_crc_low    <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_crc        <= n_crc;
            r_bytes_left <= n_bytes_left;
            r_bflag      <= n_bflag;
            r_func       <= n_func;
            r_length     <= n_length;
            r_data0      <= n_data0;
            r_data1      <= n_data1;
            r_crc_low    <= n_crc_low;
        end
    end

endmodule

// ===== rtl/crc16_frame_receiver_core.sv =====
// Top level of the CRC-16 frame receiver: register port, parser and result buffer.
`timescale 1ns / 1ps

// Byte-serial receiver for frames 0x55, 0xAA, address, function, length,
// data bytes, CRC low, CRC high (Modbus CRC-16 over address through data).
// One byte is taken every clock cycle while o_stall is low; the CRC update for
// a whole byte is combinational, via the unrolled update in the parser. A result
// (frame ok or an error code) is registered into the output or skid register
// when the byte that completes or breaks it is accepted. Results pass through
// a two-entry buffer (output register plus skid register), so input bytes
// keep flowing while a result waits; o_stall rises only once both entries
// are occupied. Address registers sit at byte offsets 0 (local) and 4
// (broadcast); write them only while no frame is in progress.
module crc16_frame_receiver_core #(
    parameter logic [7:0] LOCAL_RESET = crc16fr_pkg::LOCAL_ADDR_RESET,
    parameter logic [7:0] BCAST_RESET = crc16fr_pkg::BCAST_ADDR_RESET
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // byte input
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_rx_byte,
    // result output
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [2:0]                         o_status,
    output logic                               o_was_broadcast,
    output logic [7:0]                         o_function_code,
    output logic [7:0]                         o_payload_length,
    output logic [7:0]                         o_data_first,
    output logic [7:0]                         o_data_second,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [crc16fr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [crc16fr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [crc16fr_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);

    logic [7:0] r_local_addr, r_bcast_addr;
    logic       cfg_wr;
    crc16fr_pkg::t_reg_index cfg_idx;

    logic                 accept, res_valid, take, out_free, new_res;
    crc16fr_pkg::t_result res;
    logic                 r_out_valid, r_skid_valid;
    crc16fr_pkg::t_result r_out, r_skid;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = crc16fr_pkg::t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_addr <= LOCAL_RESET;
            r_bcast_addr <= BCAST_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                crc16fr_pkg::REG_LOCAL_ADDR: r_local_addr <= pwdata[7:0];
                crc16fr_pkg::REG_BCAST_ADDR: r_bcast_addr <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            crc16fr_pkg::REG_LOCAL_ADDR: prdata = {24'd0, r_local_addr};
            crc16fr_pkg::REG_BCAST_ADDR: prdata = {24'd0, r_bcast_addr};
            default:                     prdata = '0;
        endcase
    end

    // Parser
    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !o_stall;

    crc16fr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_rx_byte),
        .i_local_addr (r_local_addr),
        .i_bcast_addr (r_bcast_addr),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Result buffer: output register backed by a skid register
    assign take     = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || take;
    assign new_res  = accept && res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= new_res;
            end else begin
                r_out_valid  <= new_res;
            end
        end else if (new_res) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (new_res) begin
                    r_skid <= res;
                end
            end else if (new_res) begin
                r_out <= res;
            end
        end else if (new_res) begin
            r_skid <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_was_broadcast  = r_out.was_broadcast;
    assign o_function_code  = r_out.function_code;
    assign o_payload_length = r_out.payload_length;
    assign o_data_first     = r_out.data_first;
    assign o_data_second    = r_out.data_second;

endmodule
